/* hdl/assert_macros.svh */
// assertion macros used by the rate meter core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked property, disabled while reset is high
`define ASSERT_CLKD(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// clocked property, checked also during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hdl/wwrm_pkg.sv */
// shared constants and types of the weighted rate meter
`timescale 1ns / 1ps
`default_nettype none
package wwrm_pkg;
  localparam int SLOTS_DEF = 16;
  localparam logic [15:0] DECAY_RESET = 16'd58982;
  localparam int BYTES_W = 48;
  localparam int HITS_W = 32;
  localparam int SLOT_W = BYTES_W + HITS_W;
  localparam int BRATE_W = 56;
  localparam int HRATE_W = 40;
  localparam int WEIGHT_W = 17;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;
endpackage
`default_nettype wire

/* hdl/wwrm_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module wwrm_ram #(
  parameter int WIDTH = wwrm_pkg::SLOT_W,
  parameter int DEPTH = wwrm_pkg::SLOTS_DEF,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

/* hdl/windowed_weighted_rate_meter_core.sv */
// top level of the windowed weighted rate meter
//
// channel    dir  width  contents
// s_axis     in   56     opcode[1:0], event_bytes[33:2], elapsed_seconds[49:34]
// m_axis     out  224    hit_total, byte_total, byte_rate, hit_pace
// decay cfg  in   16     decay_factor, written when decay_factor_we is high
//
// one word at a time; push reads then writes back its slot, opcode 3 only emits a result
// advance: e zeroing writes (SLOTS if e >= SLOTS), read-mul-acc per completed slot,
// then one quotient bit a cycle over ACC_W bits in the restoring divider
// clear: SLOTS zeroing writes through the slot ram write port
// after reset a clearing pass over all SLOTS slots runs with s_tready low
// a result waiting on m_tready does not block the next input word
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module windowed_weighted_rate_meter_core #(
  parameter int SLOTS = wwrm_pkg::SLOTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         decay_factor_we,
  input  wire logic [15:0]  decay_factor_wdata,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // opcode[1:0], event_bytes[33:2], elapsed_seconds[49:34], zero fill
  input  wire logic [55:0]  s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // hit_total[63:0], byte_total[127:64], byte_rate[183:128], hit_pace[223:184]
  output logic      [223:0] m_tdata
);
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int LOG_S = (SLOTS > 1) ? $clog2(SLOTS) : 0;
  localparam int WS_W = wwrm_pkg::WEIGHT_W + LOG_S;
  localparam int ACC_W = 8 + wwrm_pkg::WEIGHT_W + wwrm_pkg::BYTES_W + LOG_S;
  localparam int DC_W = $clog2(ACC_W);
  localparam int BW = wwrm_pkg::BYTES_W;
  localparam int HW = wwrm_pkg::HITS_W;
  localparam int WW = wwrm_pkg::WEIGHT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH_RD, S_PUSH_WR, S_ZERO, S_RD, S_MUL, S_ACC, S_DIV, S_OUT
  } state_t;

  state_t state, after_zero;

  logic [15:0]       decay;
  logic [IDX_W-1:0]  base;
  logic [CNT_W-1:0]  zcount, zidx;
  logic [IDX_W-1:0]  slot_i;
  logic [31:0]       ev_bytes;
  logic [63:0]       run_bytes, run_hits;
  logic [wwrm_pkg::BRATE_W-1:0] held_brate;
  logic [wwrm_pkg::HRATE_W-1:0] held_hrate;
  logic [WW-1:0]     weight;
  logic [WS_W-1:0]   wsum;
  logic [ACC_W-1:0]  acc_b, acc_h;
  logic [WW+31:0]    prod_bl, prod_hl;
  logic [WW+15:0]    prod_bh;
  logic [WS_W-1:0]   rem_b, rem_h;
  logic [DC_W-1:0]   dcnt;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr, ram_raddr;
  logic [wwrm_pkg::SLOT_W-1:0] ram_wdata, ram_rdata;

  // ring position of logical slot b counted from a
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W:0] b);
    logic [IDX_W+1:0] s;
    s = (IDX_W+2)'(a) + (IDX_W+2)'(b);
    if (s >= (IDX_W+2)'(SLOTS)) begin
      s = s - (IDX_W+2)'(SLOTS);
    end
    return s[IDX_W-1:0];
  endfunction

  wire logic [1:0]  in_op = s_tdata[1:0];
  wire logic [15:0] in_elapsed = s_tdata[49:34];
  wire logic        in_acc = s_tvalid && s_tready;

  // saturating push arithmetic
  wire logic [BW-1:0] rd_bytes = ram_rdata[BW-1:0];
  wire logic [HW-1:0] rd_hits = ram_rdata[BW+HW-1:BW];
  wire logic [BW:0]   sum_b = {1'b0, rd_bytes} + (BW+1)'(ev_bytes);
  wire logic [BW-1:0] sat_b = sum_b[BW] ? {BW{1'b1}} : sum_b[BW-1:0];
  wire logic [HW-1:0] sat_h = (&rd_hits) ? rd_hits : rd_hits + HW'(1);
  wire logic [64:0]   sum_rb = {1'b0, run_bytes} + 65'(ev_bytes);
  wire logic [63:0]   sat_rb = sum_rb[64] ? {64{1'b1}} : sum_rb[63:0];
  wire logic [63:0]   sat_rh = (&run_hits) ? run_hits : run_hits + 64'd1;

  // next weight, truncated Q1.16
  wire logic [WW+15:0] wprod = weight * decay;

  // one restoring division step for each rate
  wire logic [WS_W:0] rsh_b = {rem_b, acc_b[ACC_W-1]};
  wire logic [WS_W:0] rsh_h = {rem_h, acc_h[ACC_W-1]};
  wire logic          qb_bit = rsh_b >= {1'b0, wsum};
  wire logic          qh_bit = rsh_h >= {1'b0, wsum};
  wire logic [WS_W:0] rnx_b = qb_bit ? rsh_b - {1'b0, wsum} : rsh_b;
  wire logic [WS_W:0] rnx_h = qh_bit ? rsh_h - {1'b0, wsum} : rsh_h;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = base;
    ram_wdata = {sat_h, sat_b};
    ram_raddr = base;
    case (state)
      S_PUSH_WR: begin
        ram_we = 1'b1;
      end
      S_ZERO: begin
        ram_we = 1'b1;
        ram_waddr = ring_add(base, (IDX_W+1)'(zidx));
        ram_wdata = '0;
      end
      S_RD: begin
        ram_raddr = ring_add(base, {1'b0, slot_i});
      end
      default: begin
        ram_raddr = base;
      end
    endcase
  end

  wwrm_ram #(.WIDTH(wwrm_pkg::SLOT_W), .DEPTH(SLOTS)) u_slots (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
    .rd_addr(ram_raddr), .rd_data(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ZERO;
      after_zero <= S_IDLE;
      decay <= wwrm_pkg::DECAY_RESET;
      base <= '0;
      zcount <= CNT_W'(SLOTS);
      zidx <= '0;
      run_bytes <= '0;
      run_hits <= '0;
      held_brate <= '0;
      held_hrate <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (decay_factor_we) begin
        decay <= decay_factor_wdata;
      end
      // taken word leaves unless a new one is loaded this cycle
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            ev_bytes <= s_tdata[33:2];
            zidx <= '0;
            case (wwrm_pkg::opcode_t'(in_op))
              wwrm_pkg::OP_PUSH: begin
                state <= S_PUSH_RD;
              end
              wwrm_pkg::OP_ADVANCE: begin
                after_zero <= S_RD;
                if (32'(in_elapsed) >= 32'(SLOTS)) begin
                  zcount <= CNT_W'(SLOTS);
                  state <= S_ZERO;
                end else begin
                  // new slot 0 sits e places back on the ring
                  base <= ring_add(base, (IDX_W+1)'(SLOTS - int'(in_elapsed)));
                  zcount <= CNT_W'(in_elapsed);
                  state <= (in_elapsed == 16'd0) ? S_RD : S_ZERO;
                end
                slot_i <= IDX_W'(1);
                weight <= wwrm_pkg::WEIGHT_ONE;
                wsum <= '0;
                acc_b <= '0;
                acc_h <= '0;
                if (SLOTS < 2) begin
                  held_brate <= '0;
                  held_hrate <= '0;
                  state <= S_OUT;
                end
              end
              wwrm_pkg::OP_CLEAR: begin
                run_bytes <= '0;
                run_hits <= '0;
                held_brate <= '0;
                held_hrate <= '0;
                zcount <= CNT_W'(SLOTS);
                after_zero <= S_OUT;
                state <= S_ZERO;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_PUSH_RD: begin
          state <= S_PUSH_WR;
        end
        S_PUSH_WR: begin
          run_bytes <= sat_rb;
          run_hits <= sat_rh;
          state <= S_OUT;
        end
        S_ZERO: begin
          zidx <= zidx + CNT_W'(1);
          if (zidx == zcount - CNT_W'(1)) begin
            state <= after_zero;
          end
        end
        S_RD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          // bytes split into low 32 and high 16 bits
          prod_bl <= weight * rd_bytes[31:0];
          prod_bh <= weight * rd_bytes[BW-1:32];
          prod_hl <= weight * rd_hits;
          state <= S_ACC;
        end
        S_ACC: begin
          acc_b <= acc_b + (ACC_W'(prod_bl) << 8) + (ACC_W'(prod_bh) << 40);
          acc_h <= acc_h + (ACC_W'(prod_hl) << 8);
          wsum <= wsum + WS_W'(weight);
          weight <= wprod[WW+15:16];
          slot_i <= slot_i + IDX_W'(1);
          if (32'(slot_i) == 32'(SLOTS - 1)) begin
            rem_b <= '0;
            rem_h <= '0;
            dcnt <= DC_W'(ACC_W - 1);
            state <= S_DIV;
          end else begin
            state <= S_RD;
          end
        end
        S_DIV: begin
          rem_b <= rnx_b[WS_W-1:0];
          rem_h <= rnx_h[WS_W-1:0];
          acc_b <= acc_b << 1;
          acc_h <= acc_h << 1;
          held_brate <= {held_brate[wwrm_pkg::BRATE_W-2:0], qb_bit};
          held_hrate <= {held_hrate[wwrm_pkg::HRATE_W-2:0], qh_bit};
          dcnt <= dcnt - DC_W'(1);
          if (dcnt == '0) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {held_hrate, held_brate, run_bytes, run_hits};
            m_tvalid <= 1'b1;
            state <= S_IDLE;
          end else begin
            m_tvalid <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLKD(a_base_range, clk, rst, 32'(base) < 32'(SLOTS), "ring base out of range")
  `ASSERT_CLKD(a_rem_below, clk, rst, (state == S_DIV) |-> (rem_b < wsum && rem_h < wsum), "divider remainder not below divisor")
  `ASSERT_CLKD(a_one_word, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "second word taken while busy")
endmodule
`default_nettype wire

/* verif/wwrm_checker.sv */
// checker: predicts meter results and compares them with the output stream
`timescale 1ns / 1ps
module wwrm_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         decay_factor_we,
  input  wire logic [15:0]  decay_factor_wdata,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [55:0]  s_tdata,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [223:0] m_tdata,
  output int                fail_count,
  output int                pending
);
  localparam int NS = wwrm_pkg::SLOTS_DEF;

  typedef struct packed {
    logic [39:0] hit_pace;
    logic [55:0] byte_rate;
    logic [63:0] byte_total;
    logic [63:0] hit_total;
  } meter_word_t;

  logic [15:0] alpha;
  logic [47:0] slot_b [NS];
  logic [31:0] slot_h [NS];
  logic [63:0] tot_b, tot_h;
  logic [55:0] rate_b;
  logic [39:0] rate_h;
  meter_word_t expected_words [$];

  // exact weighted mean of completed slots, 8 fraction bits
  function automatic logic [63:0] weighted_mean(input logic [47:0] vals [NS],
                                                input logic [15:0] a);
    logic [127:0] acc;
    logic [63:0] wsum;
    logic [16:0] w;
    logic [127:0] q;
    acc = '0;
    wsum = '0;
    w = wwrm_pkg::WEIGHT_ONE;
    if (NS < 2) return '0;
    for (int i = 1; i < NS; i++) begin
      acc += 128'(w) * 128'(vals[i]);
      wsum += 64'(w);
      w = 17'((34'(w) * 34'(a)) >> 16);
    end
    q = (acc << 8) / 128'(wsum);
    return q[63:0];
  endfunction

  task automatic predict(input logic [55:0] d);
    logic [1:0] op;
    logic [31:0] nb;
    logic [15:0] el;
    logic [47:0] hv [NS];
    logic [63:0] m;
    meter_word_t r;
    op = d[1:0];
    nb = d[33:2];
    el = d[49:34];
    case (op)
      wwrm_pkg::OP_PUSH: begin
        slot_b[0] = (49'(slot_b[0]) + 49'(nb) > 49'hFFFF_FFFF_FFFF) ? '1 : slot_b[0] + 48'(nb);
        slot_h[0] = (slot_h[0] == '1) ? '1 : slot_h[0] + 1;
        tot_b = (65'(tot_b) + 65'(nb) > 65'hFFFF_FFFF_FFFF_FFFF) ? '1 : tot_b + 64'(nb);
        tot_h = (tot_h == '1) ? '1 : tot_h + 1;
      end
      wwrm_pkg::OP_ADVANCE: begin
        for (int i = NS - 1; i >= 0; i--) begin
          if (el >= NS || i < el) begin
            slot_b[i] = '0;
            slot_h[i] = '0;
          end else begin
            slot_b[i] = slot_b[i - el];
            slot_h[i] = slot_h[i - el];
          end
        end
        for (int i = 0; i < NS; i++) hv[i] = 48'(slot_h[i]);
        m = weighted_mean(slot_b, alpha);
        rate_b = m[55:0];
        m = weighted_mean(hv, alpha);
        rate_h = m[39:0];
      end
      wwrm_pkg::OP_CLEAR: begin
        for (int i = 0; i < NS; i++) begin
          slot_b[i] = '0;
          slot_h[i] = '0;
        end
        tot_b = '0;
        tot_h = '0;
        rate_b = '0;
        rate_h = '0;
      end
      default: ;
    endcase
    r.hit_total = tot_h;
    r.byte_total = tot_b;
    r.byte_rate = rate_b;
    r.hit_pace = rate_h;
    expected_words.push_back(r);
  endtask

  assign pending = expected_words.size();

  always @(posedge clk) begin
    meter_word_t e, a;
    if (rst) begin
      alpha = wwrm_pkg::DECAY_RESET;
      for (int i = 0; i < NS; i++) begin
        slot_b[i] = '0;
        slot_h[i] = '0;
      end
      tot_b = '0;
      tot_h = '0;
      rate_b = '0;
      rate_h = '0;
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (decay_factor_we) alpha = decay_factor_wdata;
      if (m_tvalid && m_tready) begin
        a = m_tdata;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h", $time, m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (a != e) begin
            $display("%0t: mismatch exp ht=%h bt=%h br=%h hr=%h", $time,
                     e.hit_total, e.byte_total, e.byte_rate, e.hit_pace);
            $display("%0t:          got ht=%h bt=%h br=%h hr=%h", $time,
                     a.hit_total, a.byte_total, a.byte_rate, a.hit_pace);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) predict(s_tdata);
    end
  end
endmodule

/* verif/tb.sv */
// testbench top: stimulus, configuration phases and verdict for the rate meter
`timescale 1ns / 1ps
module tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic decay_factor_we = 1'b0;
  logic [15:0] decay_factor_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [55:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [223:0] m_tdata;
  int fail_count, pending;
  int cycle_count = 0;
  int rx_wait = 0;
  bit hold_off = 1'b0;
  bit quiet_rx = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  windowed_weighted_rate_meter_core i_dut (
    .clk, .rst, .decay_factor_we, .decay_factor_wdata,
    .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
  );

  wwrm_checker i_check (
    .clk, .rst, .decay_factor_we, .decay_factor_wdata,
    .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .fail_count, .pending
  );

  // generous watchdog limit on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 800000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random wait after each taken word, always ready when quiet, a long hold-off when asked
  always @(posedge clk) begin
    if (rst || hold_off) m_tready <= 1'b0;
    else if (quiet_rx) m_tready <= 1'b1;
    else begin
      if (m_tvalid && m_tready) rx_wait = $urandom_range(0, 4);
      if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
        m_tready <= 1'b0;
      end else m_tready <= 1'b1;
    end
  end

  // send one word, preceded by a random gap unless nogap is set
  task automatic send_word(input wwrm_pkg::opcode_t op, input logic [31:0] nb,
                           input logic [15:0] el, input bit nogap);
    int gap;
    gap = nogap ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, el, nb, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_decay(input logic [15:0] v);
    decay_factor_we <= 1'b1;
    decay_factor_wdata <= v;
    @(posedge clk);
    decay_factor_we <= 1'b0;
  endtask

  // random word: mostly pushes with some advances, rare clears and unused code
  task automatic random_word(input bit nogap);
    int k;
    logic [31:0] nb;
    logic [15:0] el;
    k = $urandom_range(0, 99);
    nb = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 5000));
    el = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    if (k < 65) send_word(wwrm_pkg::OP_PUSH, nb, el, nogap);
    else if (k < 92) send_word(wwrm_pkg::OP_ADVANCE, nb, el, nogap);
    else if (k < 96) send_word(wwrm_pkg::OP_CLEAR, nb, el, nogap);
    else send_word(wwrm_pkg::OP_NONE, nb, el, nogap);
  endtask

  initial begin
    logic [15:0] decays [4];
    decays = '{16'd1, 16'hFFFF, 16'd0, 16'd32768};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset decay, extremes, every opcode
    send_word(wwrm_pkg::OP_ADVANCE, '0, 16'd0, 1'b0);
    send_word(wwrm_pkg::OP_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_word(wwrm_pkg::OP_PUSH, 32'd0, 16'd0, 1'b0);
    send_word(wwrm_pkg::OP_PUSH, 32'hAAAA_5555, '0, 1'b0);
    send_word(wwrm_pkg::OP_ADVANCE, '0, 16'd1, 1'b0);
    send_word(wwrm_pkg::OP_PUSH, 32'h5555_AAAA, '0, 1'b0);
    send_word(wwrm_pkg::OP_ADVANCE, 32'hFFFF_FFFF, 16'd0, 1'b0);
    send_word(wwrm_pkg::OP_ADVANCE, '0, 16'd15, 1'b0);
    send_word(wwrm_pkg::OP_ADVANCE, '0, 16'd16, 1'b0);
    send_word(wwrm_pkg::OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_word(wwrm_pkg::OP_PUSH, 32'hFFFF_FFFF, '0, 1'b0);
    send_word(wwrm_pkg::OP_ADVANCE, '0, 16'd3, 1'b0);
    send_word(wwrm_pkg::OP_ADVANCE, '0, 16'hFFFF, 1'b0);
    send_word(wwrm_pkg::OP_CLEAR, '0, '0, 1'b0);
    // maximal pushes into one slot without gaps, too few to saturate its 48-bit byte count
    for (int i = 0; i < 8; i++) send_word(wwrm_pkg::OP_PUSH, 32'hFFFF_FFFF, '0, 1'b1);
    send_word(wwrm_pkg::OP_ADVANCE, '0, 16'd2, 1'b0);
    drain();

    // phases over decay settings, including both extremes and zero
    for (int p = 0; p < 5; p++) begin
      if (p < 4) write_decay(decays[p]);
      else write_decay(16'($urandom_range(1, 65535)));
      if (p == 1) begin
        // long receiver hold-off while words keep coming
        hold_off = 1'b1;
        fork
          begin repeat (300) @(posedge clk); hold_off = 1'b0; end
          for (int i = 0; i < 20; i++) random_word(1'b1);
        join
      end
      if (p == 3) quiet_rx = 1'b1;
      for (int i = 0; i < 80; i++) random_word($urandom_range(0, 3) == 0);
      quiet_rx = 1'b0;
      drain();
    end

    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
